@@ hdl/assert_macros.svh @@
// Assertion helpers for the PSR transfer block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PSR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("psr assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PSR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("psr assertion failed");

`endif

@@ hdl/psr_pkg.sv @@
package psr_pkg;

    localparam int unsigned NUM_GEN  = 16;
    localparam int unsigned GEN_AW   = 4;
    localparam int unsigned NUM_STAT = 2;

    // Operation codes
    localparam logic [1:0] OP_EXEC  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Register index map for direct access
    localparam logic [4:0] IDX_CUR_STAT   = 5'd16;
    localparam logic [4:0] IDX_SAVED_STAT = 5'd17;

    // Write controls produced by the decoder
    typedef struct packed {
        logic              gen_we;
        logic [GEN_AW-1:0] gen_waddr;
        logic              stat_we;
        logic              stat_waddr;
        logic              undef;
    } t_psr_ctrl;

endpackage

@@ hdl/psr_ram.sv @@
module psr_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/psr_decode.sv @@
module psr_decode (
    input  logic [1:0]          i_op,
    input  logic [31:0]         i_instruction,
    input  logic [4:0]          i_reg_index,
    input  logic [31:0]         i_reg_value,
    input  logic [31:0]         i_gen_rdata,
    input  logic [31:0]         i_stat_rdata,
    output psr_pkg::t_psr_ctrl  o_ctrl,
    output logic [31:0]         o_gen_wdata,
    output logic [31:0]         o_stat_wdata,
    output logic [31:0]         o_read_value
);

    localparam logic [31:0] MASK_MRS     = 32'h0FFF0FFF;
    localparam logic [31:0] MRS_CUR      = 32'h010F0FFF;
    localparam logic [31:0] MRS_SAVED    = 32'h014F0FFF;
    localparam logic [31:0] MASK_MSR_REG = 32'h0FF0FFF0;
    localparam logic [31:0] MSR_REG_CUR  = 32'h0120F000;
    localparam logic [31:0] MSR_REG_SAV  = 32'h0160F000;
    localparam logic [31:0] MASK_MSR_IMM = 32'h0FF0F000;
    localparam logic [31:0] MSR_IMM_CUR  = 32'h0320F000;
    localparam logic [31:0] MSR_IMM_SAV  = 32'h0360F000;
    localparam logic [31:0] FORCED_BIT   = 32'h00000010;

    logic        is_mrs;
    logic        is_msr_reg;
    logic        is_msr_imm;
    logic [63:0] imm_dbl;
    logic [63:0] imm_shifted;
    logic [4:0]  rot_amt;
    logic [31:0] operand;
    logic [31:0] byte_mask;
    logic [31:0] merged;
    logic        is_exec;
    logic        is_write;
    logic        idx_gen;
    logic        idx_stat;

    assign is_mrs = ((i_instruction & MASK_MRS) == MRS_CUR)
                 || ((i_instruction & MASK_MRS) == MRS_SAVED);
    assign is_msr_reg = ((i_instruction & MASK_MSR_REG) == MSR_REG_CUR)
                     || ((i_instruction & MASK_MSR_REG) == MSR_REG_SAV);
    assign is_msr_imm = ((i_instruction & MASK_MSR_IMM) == MSR_IMM_CUR)
                     || ((i_instruction & MASK_MSR_IMM) == MSR_IMM_SAV);

    // Rotate the 8-bit immediate right by twice the rotate field
    assign rot_amt     = {i_instruction[11:8], 1'b0};
    assign imm_dbl     = {24'd0, i_instruction[7:0], 24'd0, i_instruction[7:0]};
    assign imm_shifted = imm_dbl >> rot_amt;
    assign operand     = is_msr_imm ? imm_shifted[31:0] : i_gen_rdata;

    always_comb begin
        for (int b = 0; b < 4; b++) begin
            byte_mask[8*b +: 8] = {8{i_instruction[16+b]}};
        end
    end

    assign merged = (i_stat_rdata & ~byte_mask) | (operand & byte_mask) | FORCED_BIT;

    assign is_exec  = (i_op == psr_pkg::OP_EXEC);
    assign is_write = (i_op == psr_pkg::OP_WRITE);
    assign idx_gen  = ~i_reg_index[4];
    assign idx_stat = (i_reg_index == psr_pkg::IDX_CUR_STAT)
                   || (i_reg_index == psr_pkg::IDX_SAVED_STAT);

    always_comb begin
        o_ctrl.gen_we     = (is_exec && is_mrs) || (is_write && idx_gen);
        o_ctrl.gen_waddr  = is_write ? i_reg_index[3:0] : i_instruction[15:12];
        o_ctrl.stat_we    = (is_exec && (is_msr_reg || is_msr_imm))
                         || (is_write && idx_stat);
        o_ctrl.stat_waddr = is_write ? i_reg_index[0] : i_instruction[22];
        o_ctrl.undef      = is_exec && !(is_mrs || is_msr_reg || is_msr_imm);
    end

    assign o_gen_wdata  = is_write ? i_reg_value : i_stat_rdata;
    assign o_stat_wdata = is_write ? i_reg_value : merged;

    always_comb begin
        o_read_value = '0;
        if (i_op == psr_pkg::OP_READ) begin
            if (idx_gen) begin
                o_read_value = i_gen_rdata;
            end else if (idx_stat) begin
                o_read_value = i_stat_rdata;
            end
        end
    end

endmodule

@@ hdl/psr_transfer_execute_core.sv @@
// Status-register transfer unit: executes MRS/MSR words against a 16-entry
// general register file and the current/saved status registers, and offers
// direct register write and read. An item is accepted in the idle state, when
// the register and status memories are read (registered), and is merged,
// written back and loaded into the result register in the execute state; none
// is accepted while one executes, but one may be while the result register
// drains; i_out_stall on a held result keeps the unit executing. Reset clears
// all registers at once through per-entry valid bits, with no clearing pass.
`include "assert_macros.svh"

module psr_transfer_execute_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_op,
    input  logic [31:0] i_instruction,
    input  logic [4:0]  i_reg_index,
    input  logic [31:0] i_reg_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_status,
    output logic [31:0] o_read_value
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic                       r_state;
    logic                       n_state;
    logic [1:0]                 r_op;
    logic [31:0]                r_instruction;
    logic [4:0]                 r_reg_index;
    logic [31:0]                r_reg_value;
    logic [psr_pkg::GEN_AW-1:0] r_gen_raddr;
    logic                       r_stat_raddr;
    logic [psr_pkg::NUM_GEN-1:0]  r_gen_vld;
    logic [psr_pkg::NUM_STAT-1:0] r_stat_vld;
    logic                       r_out_valid;
    logic                       r_status;
    logic [31:0]                r_read_value;

    logic                       in_xfer;
    logic                       out_free;
    logic                       exec_go;
    logic [psr_pkg::GEN_AW-1:0] in_gen_raddr;
    logic                       in_stat_raddr;
    logic [psr_pkg::GEN_AW-1:0] gen_raddr;
    logic                       stat_raddr;
    logic [31:0]                gen_rdata_raw;
    logic [31:0]                stat_rdata_raw;
    logic [31:0]                gen_rdata;
    logic [31:0]                stat_rdata;
    psr_pkg::t_psr_ctrl         ctrl;
    logic [31:0]                gen_wdata;
    logic [31:0]                stat_wdata;
    logic [31:0]                read_value;
    logic                       gen_we;
    logic                       stat_we;

    assign o_in_stall = (r_state == S_EXEC);
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign exec_go    = (r_state == S_EXEC) && out_free;

    // Read ports follow the incoming item, then hold while it executes
    assign in_gen_raddr  = (i_op == psr_pkg::OP_READ) ? i_reg_index[3:0]
                                                      : i_instruction[3:0];
    assign in_stat_raddr = (i_op == psr_pkg::OP_READ) ? i_reg_index[0]
                                                      : i_instruction[22];
    assign gen_raddr  = (r_state == S_EXEC) ? r_gen_raddr  : in_gen_raddr;
    assign stat_raddr = (r_state == S_EXEC) ? r_stat_raddr : in_stat_raddr;

    psr_ram #(.WIDTH(32), .DEPTH(psr_pkg::NUM_GEN)) u_gen_ram (
        .i_clk   (i_clk),
        .i_we    (gen_we),
        .i_waddr (ctrl.gen_waddr),
        .i_wdata (gen_wdata),
        .i_raddr (gen_raddr),
        .o_rdata (gen_rdata_raw)
    );

    psr_ram #(.WIDTH(32), .DEPTH(psr_pkg::NUM_STAT)) u_stat_ram (
        .i_clk   (i_clk),
        .i_we    (stat_we),
        .i_waddr (ctrl.stat_waddr),
        .i_wdata (stat_wdata),
        .i_raddr (stat_raddr),
        .o_rdata (stat_rdata_raw)
    );

    // Entries never written since reset read as zero
    assign gen_rdata  = r_gen_vld[r_gen_raddr]   ? gen_rdata_raw  : '0;
    assign stat_rdata = r_stat_vld[r_stat_raddr] ? stat_rdata_raw : '0;

    psr_decode u_decode (
        .i_op          (r_op),
        .i_instruction (r_instruction),
        .i_reg_index   (r_reg_index),
        .i_reg_value   (r_reg_value),
        .i_gen_rdata   (gen_rdata),
        .i_stat_rdata  (stat_rdata),
        .o_ctrl        (ctrl),
        .o_gen_wdata   (gen_wdata),
        .o_stat_wdata  (stat_wdata),
        .o_read_value  (read_value)
    );

    assign gen_we  = exec_go && ctrl.gen_we;
    assign stat_we = exec_go && ctrl.stat_we;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_gen_vld   <= '0;
            r_stat_vld  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (gen_we) begin
                r_gen_vld[ctrl.gen_waddr] <= 1'b1;
            end
            if (stat_we) begin
                r_stat_vld[ctrl.stat_waddr] <= 1'b1;
            end
            if (exec_go) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_op          <= i_op;
            r_instruction <= i_instruction;
            r_reg_index   <= i_reg_index;
            r_reg_value   <= i_reg_value;
            r_gen_raddr   <= in_gen_raddr;
            r_stat_raddr  <= in_stat_raddr;
        end
        if (exec_go) begin
            r_status     <= ctrl.undef;
            r_read_value <= read_value;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_read_value = r_read_value;

    `PSR_ASSERT_NEXT(a_accept_to_exec, i_clk, i_rst_n, in_xfer, r_state == S_EXEC)
    `PSR_ASSERT_NEXT(a_exec_loads_out, i_clk, i_rst_n, exec_go, r_out_valid)
    `PSR_ASSERT_NOW(a_one_mem_write, i_clk, i_rst_n, gen_we, !stat_we)
    `PSR_ASSERT_NOW(a_undef_no_write, i_clk, i_rst_n, exec_go && ctrl.undef, !gen_we && !stat_we && read_value == 32'd0)

endmodule
